[hdl/integer_to_radix_text_defines.svh]
// assertion macros used by the verification file of integer_to_radix_text
`ifndef INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define I2RT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is held
`define I2RT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/i2rt_pkg.sv]
// shared types, constants and helper functions of integer_to_radix_text
package i2rt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_HUND,
    PH_TENS,
    PH_ONES,
    PH_COMMA
  } phase_t;

  typedef struct packed {
    logic       hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_t;

  localparam int unsigned RADIX_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
  localparam logic [RADIX_W-1:0] MIN_RADIX   = 7'd2;
  localparam logic [RADIX_W-1:0] HEX_LIMIT   = 7'd16;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;

  // register select: address bit 2 picks the register slot
  localparam logic ADDR_RADIX = 1'b0;

  // 0-9 then A-F
  function automatic logic [7:0] hex_glyph(input logic [3:0] d);
    logic [7:0] res;
    if (d < 4'd10) begin
      res = ASCII_ZERO + {4'b0, d};
    end else begin
      res = ASCII_A + {4'b0, d} - 8'd10;
    end
    return res;
  endfunction

  // decimal split of a digit up to 127 by compares and subtraction
  function automatic dec_t dec_split(input logic [6:0] d);
    dec_t       res;
    logic [6:0] r;
    logic [6:0] t10;
    res = '0;
    r   = d;
    if (d >= 7'd100) begin
      res.hund = 1'b1;
      r        = d - 7'd100;
    end
    for (int k = 9; k >= 1; k--) begin
      if (res.tens == 4'd0 && r >= 7'(10 * k)) begin
        res.tens = 4'(k);
      end
    end
    t10      = {res.tens, 3'b000} + {2'b00, res.tens, 1'b0};
    res.ones = 4'(r - t10);
    return res;
  endfunction

endpackage

[hdl/integer_to_radix_text.sv]
// integer_to_radix_text: signed integer to text in a set base, one character per transaction
//
//  channel  | direction | transaction contents
//  ---------+-----------+----------------------------------------------------
//  in_*     | slave     | tdata: value (VALUE_BITS, two's complement)
//  out_*    | master    | tdata: text_char (8); tlast: last character of the text
//  cfg_*    | APB slave | radix at byte address 0 (7 bits, reset 10)
//
// one value at a time: each digit takes VALUE_BITS steps of a bit-serial
// restoring divide (one quotient bit per cycle through a 7-bit remainder),
// then comes the sign step, and the characters leave as out_tready allows;
// bases above 16 emit each digit as decimal text with leading zeros dropped
// and commas between.
// synchronous active-low reset clears control and sets radix to 10.
// a stalled output holds its character; the divider can run on the next value meanwhile.
module integer_to_radix_text #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,   // [VALUE_BITS-1:0] value
  // output stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata,  // [7:0] text_char
  output logic                                  out_tlast,
  // configuration
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [2:0]                            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned NDIG_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned BIT_W  = $clog2(VALUE_BITS);
  localparam int unsigned RW     = i2rt_pkg::RADIX_W;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [RW-1:0] radix_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == i2rt_pkg::ADDR_RADIX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= i2rt_pkg::RADIX_RESET;
    end else if (cfg_wr) begin
      radix_r <= cfg_pwdata[RW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == i2rt_pkg::ADDR_RADIX) ?
                      {{(32 - RW){1'b0}}, radix_r} : 32'd0;

  // ---------------------------------------------------------------------------
  // datapath and control registers
  // ---------------------------------------------------------------------------
  i2rt_pkg::state_t state_r, state_nxt;
  i2rt_pkg::phase_t phase_r, phase_nxt;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;        // dividend, quotient shifts in at the bottom
  logic [RW-1:0]         rem_r, rem_nxt;        // running remainder
  logic [RW-1:0]         base_r, base_nxt;      // effective base latched per value
  logic                  neg_r, neg_nxt;
  logic [BIT_W-1:0]      bitcnt_r, bitcnt_nxt;
  logic [NDIG_W-1:0]     ndig_r, ndig_nxt;      // digits held on the stack

  // digit stack: top (most significant digit) sits at entry 0
  logic [RW-1:0] stk_r [VALUE_BITS];
  logic          push, pop;

  // input side
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] raw_mag;
  logic [RW-1:0]         base_eff;
  logic                  in_acc;

  assign raw      = in_tdata[VALUE_BITS-1:0];
  assign raw_mag  = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : raw;
  assign base_eff = (radix_r < i2rt_pkg::MIN_RADIX) ? i2rt_pkg::MIN_RADIX : radix_r;
  assign in_tready = (state_r == i2rt_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // one restoring-division step
  logic [RW:0]           trial;
  logic [RW:0]           diff;
  logic                  qbit;
  logic [RW-1:0]         rem_step;
  logic [VALUE_BITS-1:0] quo_step;
  logic                  last_bit;

  assign trial    = {rem_r, mag_r[VALUE_BITS-1]};
  assign diff     = trial - {1'b0, base_r};
  assign qbit     = (trial >= {1'b0, base_r});
  assign rem_step = qbit ? diff[RW-1:0] : trial[RW-1:0];
  assign quo_step = {mag_r[VALUE_BITS-2:0], qbit};
  assign last_bit = (bitcnt_r == BIT_W'(VALUE_BITS - 1));

  // character formation from the top digit
  i2rt_pkg::dec_t dec;
  logic [7:0]     glyph;
  logic           large_base;
  logic           final_digit;

  assign dec         = i2rt_pkg::dec_split(stk_r[0]);
  assign glyph       = i2rt_pkg::hex_glyph(stk_r[0][3:0]);
  assign large_base  = (base_r > i2rt_pkg::HEX_LIMIT);
  assign final_digit = (ndig_r == NDIG_W'(1));

  // output register
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       slot_free;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;

  assign slot_free = !out_valid_r || out_tready;

  // ---------------------------------------------------------------------------
  // sequencer: next state and step controls
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    mag_nxt    = mag_r;
    rem_nxt    = rem_r;
    base_nxt   = base_r;
    neg_nxt    = neg_r;
    bitcnt_nxt = bitcnt_r;
    ndig_nxt   = ndig_r;
    push       = 1'b0;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_char  = glyph;
    emit_last  = 1'b0;

    unique case (state_r)
      i2rt_pkg::ST_IDLE: begin
        if (in_acc) begin
          mag_nxt    = raw_mag;
          neg_nxt    = raw[VALUE_BITS-1];
          base_nxt   = base_eff;
          rem_nxt    = '0;
          bitcnt_nxt = '0;
          ndig_nxt   = '0;
          state_nxt  = i2rt_pkg::ST_DIV;
        end
      end

      i2rt_pkg::ST_DIV: begin
        mag_nxt    = quo_step;
        rem_nxt    = rem_step;
        bitcnt_nxt = bitcnt_r + BIT_W'(1);
        if (last_bit) begin
          // digit done: stack the remainder, restart on the quotient
          push       = 1'b1;
          ndig_nxt   = ndig_r + NDIG_W'(1);
          rem_nxt    = '0;
          bitcnt_nxt = '0;
          if (quo_step == '0) begin
            state_nxt = i2rt_pkg::ST_SIGN;
          end
        end
      end

      i2rt_pkg::ST_SIGN: begin
        phase_nxt = i2rt_pkg::PH_HUND;
        if (!neg_r) begin
          state_nxt = i2rt_pkg::ST_EMIT;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = i2rt_pkg::ASCII_MINUS;
          state_nxt = i2rt_pkg::ST_EMIT;
        end
      end

      i2rt_pkg::ST_EMIT: begin
        if (!large_base) begin
          // one glyph per digit
          emit_char = glyph;
          emit_last = final_digit;
          if (slot_free) begin
            emit     = 1'b1;
            pop      = 1'b1;
            ndig_nxt = ndig_r - NDIG_W'(1);
            if (final_digit) begin
              state_nxt = i2rt_pkg::ST_IDLE;
            end
          end
        end else begin
          // decimal text per digit, leading zeros dropped, commas between
          unique case (phase_r)
            i2rt_pkg::PH_HUND: begin
              emit_char = i2rt_pkg::ASCII_ZERO + {7'b0, dec.hund};
              if (!dec.hund) begin
                phase_nxt = i2rt_pkg::PH_TENS;
              end else if (slot_free) begin
                emit      = 1'b1;
                phase_nxt = i2rt_pkg::PH_TENS;
              end
            end
            i2rt_pkg::PH_TENS: begin
              emit_char = i2rt_pkg::ASCII_ZERO + {4'b0, dec.tens};
              if (!dec.hund && dec.tens == 4'd0) begin
                phase_nxt = i2rt_pkg::PH_ONES;
              end else if (slot_free) begin
                emit      = 1'b1;
                phase_nxt = i2rt_pkg::PH_ONES;
              end
            end
            i2rt_pkg::PH_ONES: begin
              emit_char = i2rt_pkg::ASCII_ZERO + {4'b0, dec.ones};
              emit_last = final_digit;
              if (slot_free) begin
                emit = 1'b1;
                if (final_digit) begin
                  state_nxt = i2rt_pkg::ST_IDLE;
                end else begin
                  phase_nxt = i2rt_pkg::PH_COMMA;
                end
              end
            end
            i2rt_pkg::PH_COMMA: begin
              emit_char = i2rt_pkg::ASCII_COMMA;
              if (slot_free) begin
                emit      = 1'b1;
                pop       = 1'b1;
                ndig_nxt  = ndig_r - NDIG_W'(1);
                phase_nxt = i2rt_pkg::PH_HUND;
              end
            end
            default: begin
              phase_nxt = i2rt_pkg::PH_HUND;
            end
          endcase
        end
      end

      default: begin
        state_nxt = i2rt_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= i2rt_pkg::ST_IDLE;
      phase_r  <= i2rt_pkg::PH_HUND;
      bitcnt_r <= '0;
      ndig_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      bitcnt_r <= bitcnt_nxt;
      ndig_r   <= ndig_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
    neg_r  <= neg_nxt;
  end

  // digit stack: push shifts down, pop shifts up
  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= rem_step;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register: the sequencer refills it in the cycle it is taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/i2rt_checker.sv]
// port-level checks for integer_to_radix_text and their binding
`include "integer_to_radix_text_defines.svh"

module i2rt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic       out_stall;
  logic [8:0] out_beat;
  logic       out_is_sep;
  logic       out_is_digit;
  logic       out_is_hex;

  assign out_stall    = out_tvalid && !out_tready;
  assign out_beat     = {out_tlast, out_tdata};
  assign out_is_sep   = (out_tdata == i2rt_pkg::ASCII_COMMA) ||
                        (out_tdata == i2rt_pkg::ASCII_MINUS);
  assign out_is_digit = (out_tdata >= i2rt_pkg::ASCII_ZERO) &&
                        (out_tdata <= i2rt_pkg::ASCII_ZERO + 8'd9);
  assign out_is_hex   = (out_tdata >= i2rt_pkg::ASCII_A) &&
                        (out_tdata <= i2rt_pkg::ASCII_A + 8'd5);

  // a stalled character holds
  `I2RT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_beat), "stall moved output")

  // one value at a time: no second transaction right after one is taken
  `I2RT_ASSERT_NEXT(a_in_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // only sign, comma, decimal or hex glyphs leave the block
  `I2RT_ASSERT_NOW(a_out_charset, clk, rst_n, out_tvalid, out_is_sep || out_is_digit || out_is_hex, "bad char")

  // text never ends on a sign or separator
  `I2RT_ASSERT_NOW(a_last_is_digit, clk, rst_n, out_tvalid && out_is_sep, !out_tlast, "text ends on sign or comma")

endmodule

bind integer_to_radix_text i2rt_checker u_i2rt_checker (.*);
